@@ hw/rtl/gst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gst_pkg: shared types, constants and exponent table for the spot generator
// Holds the register map, the configuration and pipeline control structs,
// and the elaboration-time build of the exp(-k/128) lookup table.
// ----------------------------------------------------------------------------
package gst_pkg;

    // Texture size limits and derived widths.
    localparam int MAX_DIM       = 1024;
    localparam int DIM_W         = $clog2(MAX_DIM) + 1;     // size register width
    localparam int COORD_W       = $clog2(MAX_DIM);         // coordinate width
    localparam int DIFF_W        = COORD_W + 3;             // signed 2*c - size
    localparam int SQ_W          = 2 * COORD_W + 1;         // square while in range
    localparam int D4_W          = SQ_W + 1;
    localparam int IDX_W         = 20;
    localparam int SCALE_W       = 32;
    localparam int PROD_W        = D4_W + SCALE_W;
    localparam int K_SHIFT       = 25;

    // Exponent table.
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int EXP_ADDR_W      = $clog2(EXP_TABLE_DEPTH);
    localparam int EXP_W           = 16;

    // Pipeline depth.
    localparam int NSTG = 6;

    // APB register map (word index).
    localparam int APB_ADDR_W = 5;
    localparam logic [2:0] REG_TEX_WIDTH    = 3'd0;
    localparam logic [2:0] REG_TEX_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_RED_LEVEL    = 3'd2;
    localparam logic [2:0] REG_GREEN_LEVEL  = 3'd3;
    localparam logic [2:0] REG_BLUE_LEVEL   = 3'd4;
    localparam logic [2:0] REG_PEAK_OPACITY = 3'd5;
    localparam logic [2:0] REG_EXP_SCALE    = 3'd6;

    typedef struct packed {
        logic [DIM_W-1:0]   tex_width;
        logic [DIM_W-1:0]   tex_height;
        logic [7:0]         red_level;
        logic [7:0]         green_level;
        logic [7:0]         blue_level;
        logic [7:0]         peak_opacity;
        logic [SCALE_W-1:0] exp_scale;
    } t_cfg;

    typedef struct packed {
        logic [NSTG-1:0] en;    // per-stage load enable
    } t_pipe_ctl;

    typedef logic [EXP_W-1:0] t_exp_rom [EXP_TABLE_DEPTH];

    // Product of two Q56 values, result in Q56.
    function automatic logic [63:0] f_q56_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = {32'd0, a[31:0]};
        ah  = a >> 32;
        bl  = {32'd0, b[31:0]};
        bh  = b >> 32;
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        lo  = (mid << 32) | {32'd0, ll[31:0]};
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 8) | (lo >> 56);
    endfunction

    // Unsigned quotient by restoring shift and subtract; the divisor is small.
    function automatic logic [63:0] f_udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo, rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-m/128) in Q56 for m up to 128, by an alternating Taylor series.
    function automatic logic [63:0] f_q56_exp_frac(logic [63:0] m);
        logic [63:0] term, sum;
        term = 64'd1 << 56;
        sum  = 64'd1 << 56;
        for (int n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                term = f_udiv64(term * m, 64'd128 * 64'(n));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // Table entry k holds round(65535 * exp(-k/128)).
    function automatic t_exp_rom f_build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] inv_e, v, q;
        inv_e = f_q56_exp_frac(64'd128);
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            v = f_q56_exp_frac(64'(k % 128));
            for (int j = 0; j < k / 128; j++) begin
                v = f_q56_mul(v, inv_e);
            end
            v = v >> 24;
            q = (64'd65535 * v + (64'd1 << 31)) >> 32;
            rom[k] = q[EXP_W-1:0];
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = f_build_exp_rom();

endpackage
`default_nettype wire

@@ hw/rtl/gst_apb_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gst_apb_regs: configuration register file
// APB slave holding texture size, colour, peak opacity and exponent scale.
// ----------------------------------------------------------------------------
module gst_apb_regs
    import gst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Register writes; unknown indices are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_width    <= DIM_W'(128);
            r_cfg.tex_height   <= DIM_W'(128);
            r_cfg.red_level    <= 8'd255;
            r_cfg.green_level  <= 8'd255;
            r_cfg.blue_level   <= 8'd255;
            r_cfg.peak_opacity <= 8'd255;
            r_cfg.exp_scale    <= SCALE_W'(65536);
        end else if (wr_en) begin
            case (reg_idx)
                REG_TEX_WIDTH:    r_cfg.tex_width    <= pwdata[DIM_W-1:0];
                REG_TEX_HEIGHT:   r_cfg.tex_height   <= pwdata[DIM_W-1:0];
                REG_RED_LEVEL:    r_cfg.red_level    <= pwdata[7:0];
                REG_GREEN_LEVEL:  r_cfg.green_level  <= pwdata[7:0];
                REG_BLUE_LEVEL:   r_cfg.blue_level   <= pwdata[7:0];
                REG_PEAK_OPACITY: r_cfg.peak_opacity <= pwdata[7:0];
                REG_EXP_SCALE:    r_cfg.exp_scale    <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            REG_TEX_WIDTH:    prdata = 32'(r_cfg.tex_width);
            REG_TEX_HEIGHT:   prdata = 32'(r_cfg.tex_height);
            REG_RED_LEVEL:    prdata = 32'(r_cfg.red_level);
            REG_GREEN_LEVEL:  prdata = 32'(r_cfg.green_level);
            REG_BLUE_LEVEL:   prdata = 32'(r_cfg.blue_level);
            REG_PEAK_OPACITY: prdata = 32'(r_cfg.peak_opacity);
            REG_EXP_SCALE:    prdata = 32'(r_cfg.exp_scale);
            default:          prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/gst_pipe_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gst_pipe_ctrl: pipeline valid and stall control
// Carries one valid bit per stage; a stage loads when it is empty or when
// the stage after it moves, so bubbles collapse and stalls lose nothing.
// ----------------------------------------------------------------------------
module gst_pipe_ctrl
    import gst_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    input  wire logic i_m_tready,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    output t_pipe_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] n_vld;

    // Ready chain from the output register backwards.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // Valid bits follow the data.
    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_s_tvalid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_ctl.en   = en;

endmodule
`default_nettype wire

@@ hw/rtl/gst_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gst_datapath: six-stage texel arithmetic
// Offsets, squares and linear index, distance sum, exponent scaling,
// table lookup and opacity product, ending in the output register.
// ----------------------------------------------------------------------------
module gst_datapath
    import gst_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cfg               i_cfg,
    input  wire t_pipe_ctl          i_ctl,
    input  wire logic [COORD_W-1:0] i_col,
    input  wire logic [COORD_W-1:0] i_row,
    output logic      [7:0]         o_red,
    output logic      [7:0]         o_green,
    output logic      [7:0]         o_blue,
    output logic      [7:0]         o_alpha,
    output logic      [IDX_W-1:0]   o_texel_index,
    output logic                    o_in_range
);

    logic [DIM_W-1:0] w_clamp, h_clamp;

    // Sizes above the maximum are used saturated.
    assign w_clamp = (i_cfg.tex_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.tex_width;
    assign h_clamp = (i_cfg.tex_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.tex_height;

    // Stage 0: doubled offsets from the centre and range check.
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [COORD_W-1:0]       r_col0, r_row0;
    logic                     r_inr0;
    logic [DIFF_W-1:0]        dx, dy;

    assign dx = {2'b00, i_col, 1'b0} - {2'b00, w_clamp};
    assign dy = {2'b00, i_row, 1'b0} - {2'b00, h_clamp};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_dx   <= $signed(dx);
            r_dy   <= $signed(dy);
            r_col0 <= i_col;
            r_row0 <= i_row;
            r_inr0 <= ({1'b0, i_col} < w_clamp) && ({1'b0, i_row} < h_clamp);
        end
    end

    // Stage 1: squares and linear index. The squares fit SQ_W bits in range.
    logic signed [2*DIFF_W-1:0] sq_x, sq_y;
    logic [COORD_W+DIM_W-1:0]   idx_prod;
    logic [SQ_W-1:0]            r_sqx, r_sqy;
    logic [IDX_W-1:0]           r_idx1;
    logic                       r_inr1;

    assign sq_x     = r_dx * r_dx;
    assign sq_y     = r_dy * r_dy;
    assign idx_prod = (COORD_W+DIM_W)'(r_col0) * (COORD_W+DIM_W)'(h_clamp);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_sqx  <= sq_x[SQ_W-1:0];
            r_sqy  <= sq_y[SQ_W-1:0];
            r_idx1 <= IDX_W'(idx_prod + (COORD_W+DIM_W)'(r_row0));
            r_inr1 <= r_inr0;
        end
    end

    // Stage 2: squared distance.
    logic [D4_W-1:0]  r_d4;
    logic [IDX_W-1:0] r_idx2;
    logic             r_inr2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_d4   <= D4_W'(r_sqx) + D4_W'(r_sqy);
            r_idx2 <= r_idx1;
            r_inr2 <= r_inr1;
        end
    end

    // Stage 3: exponent index k = (d4 * scale) >> 25 and far-range flag.
    logic [PROD_W-1:0]     prod;
    logic [EXP_ADDR_W-1:0] r_kidx3;
    logic                  r_far3;
    logic [IDX_W-1:0]      r_idx3;
    logic                  r_inr3;

    assign prod = PROD_W'(r_d4) * PROD_W'(i_cfg.exp_scale);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_kidx3 <= prod[K_SHIFT +: EXP_ADDR_W];
            r_far3  <= |prod[PROD_W-1:K_SHIFT+EXP_ADDR_W];
            r_idx3  <= r_idx2;
            r_inr3  <= r_inr2;
        end
    end

    // Stage 4: registered table read.
    logic [EXP_W-1:0] r_exp4;
    logic             r_far4;
    logic [IDX_W-1:0] r_idx4;
    logic             r_inr4;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_exp4 <= EXP_ROM[r_kidx3];
            r_far4 <= r_far3;
            r_idx4 <= r_idx3;
            r_inr4 <= r_inr3;
        end
    end

    // Stage 5: opacity product and output register; out of range gives zeros.
    logic [EXP_W+7:0] alpha_prod;
    logic [7:0]       r_red, r_green, r_blue, r_alpha;
    logic [IDX_W-1:0] r_idx5;
    logic             r_inr5;

    assign alpha_prod = (EXP_W+8)'(i_cfg.peak_opacity) * (EXP_W+8)'(r_exp4);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_red   <= r_inr4 ? i_cfg.red_level   : 8'd0;
            r_green <= r_inr4 ? i_cfg.green_level : 8'd0;
            r_blue  <= r_inr4 ? i_cfg.blue_level  : 8'd0;
            r_alpha <= (r_inr4 && !r_far4) ? alpha_prod[EXP_W +: 8] : 8'd0;
            r_idx5  <= r_inr4 ? r_idx4 : '0;
            r_inr5  <= r_inr4;
        end
    end

    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_alpha       = r_alpha;
    assign o_texel_index = r_idx5;
    assign o_in_range    = r_inr5;

endmodule
`default_nettype wire

@@ hw/rtl/gaussian_spot_texel_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_spot_texel_generator_top: Gaussian spot texel source
// Returns fixed RGB bytes, a Gaussian opacity centred on the texture and the
// linear texel index for each requested coordinate.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         col, row request
//  m_axis    out        red, green, blue, alpha, texel_index; tuser in_range
//  apb       in/out     configuration registers at byte address 4*i
//
// One request is taken per cycle while the output is not stalled; its result
// passes through the six register stages of the datapath, the first of which
// loads at the accepting edge.
// Reset clears the stage valid bits and loads the register defaults.
// A stall at the output backs up stage by stage; empty stages keep loading.
// ----------------------------------------------------------------------------
module gaussian_spot_texel_generator_top
    import gst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request stream.
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [23:0]           i_s_tdata,   // col[9:0], row[19:10], zero
    // Result stream.
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [55:0]           o_m_tdata,   // red, green, blue, alpha,
                                                    // texel_index[51:32], zero
    output logic                       o_m_tuser,   // in_range
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    t_cfg             cfg;
    t_pipe_ctl        ctl;
    logic [7:0]       red, green, blue, alpha;
    logic [IDX_W-1:0] texel_index;

    gst_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gst_pipe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_ctl      (ctl)
    );

    gst_datapath u_dp (
        .i_clk         (i_clk),
        .i_cfg         (cfg),
        .i_ctl         (ctl),
        .i_col         (i_s_tdata[COORD_W-1:0]),
        .i_row         (i_s_tdata[2*COORD_W-1:COORD_W]),
        .o_red         (red),
        .o_green       (green),
        .o_blue        (blue),
        .o_alpha       (alpha),
        .o_texel_index (texel_index),
        .o_in_range    (o_m_tuser)
    );

    // Pack the result fields from the lowest bit up.
    assign o_m_tdata = {4'd0, texel_index, alpha, blue, green, red};

endmodule
`default_nettype wire

@@ hw/rtl/gst_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gst_checker: port-level checks for the spot generator
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module gst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tready,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [55:0] i_m_tdata,
    input wire logic        i_m_tuser
);

    // A result outside the texture carries all-zero fields.
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tdata == 56'd0)
        else $error("out-of-range result with non-zero fields");

    // The pipeline never refuses a request while its output is free to move.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_tvalid || i_m_tready |-> i_s_tready)
        else $error("request refused while output can drain");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid straight after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser))
        else $error("stalled result changed");

endmodule

bind gaussian_spot_texel_generator_top gst_checker u_gst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
`default_nettype wire
